[src/utf8d_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared types and constants for the streaming UTF-8 decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int unsigned CpWidth    = 21;
  localparam int unsigned OutCntW    = 16;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CpWidth-1:0] MinTwoByte   = 21'h000080;
  localparam logic [CpWidth-1:0] MinThreeByte = 21'h000800;
  localparam logic [CpWidth-1:0] MinFourByte  = 21'h010000;
  localparam logic [CpWidth-1:0] SurrogateLo  = 21'h00D800;
  localparam logic [CpWidth-1:0] SurrogateHi  = 21'h00DFFF;
  localparam logic [CpWidth-1:0] MaxScalar    = 21'h10FFFF;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_CONT,
    CLS_BAD
  } byte_cls_e;

  typedef struct packed {
    byte_cls_e  cls;
    logic [6:0] data;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               has_code_point;
    logic               status;
    logic               end_of_message;
    logic [OutCntW-1:0] decoded_count;
  } result_t;

endpackage

[src/utf8d_front.sv]
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts input bytes and registers them with their byte class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8d_front import utf8d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_byte_i,
  output beat_t      beat_o,
  output logic       beat_valid_o,
  input  logic       beat_ready_i
);

  logic  vld_q;
  beat_t beat_q, beat_d;

  assign in_ready_o   = !vld_q || beat_ready_i;
  assign beat_o       = beat_q;
  assign beat_valid_o = vld_q;

  always_comb begin
    beat_d.data = in_byte_i[6:0];
    beat_d.last = last_byte_i;
    if (!in_byte_i[7]) begin
      beat_d.cls = CLS_ASCII;
    end else if (in_byte_i[7:6] == 2'b10) begin
      beat_d.cls = CLS_CONT;
    end else if (in_byte_i[7:5] == 3'b110) begin
      beat_d.cls = CLS_LEAD2;
    end else if (in_byte_i[7:4] == 4'b1110) begin
      beat_d.cls = CLS_LEAD3;
    end else if (in_byte_i[7:3] == 5'b11110) begin
      beat_d.cls = CLS_LEAD4;
    end else begin
      beat_d.cls = CLS_BAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      beat_q <= beat_d;
    end
  end

endmodule

[src/utf8d_fifo.sv]
// ----------------------------------------------------------------------------
// UTF-8 decoder beat queue
// Short queue of classified beats between front end and decode stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8d_fifo import utf8d_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  beat_t data_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output beat_t data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  beat_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign data_o       = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[src/utf8d_back.sv]
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Sequence assembly, validity checks, counting and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8d_back import utf8d_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  beat_t   beat_i,
  input  logic    beat_valid_i,
  output logic    beat_ready_o,
  output result_t result_o,
  output logic    empty_o,
  input  logic    pop_i
);

  logic [CpWidth-1:0]     partial_q, partial_d;
  logic [1:0]             rem_q, rem_d;
  logic [1:0]             len_q, len_d;
  logic                   err_q, err_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   out_vld_q, out_vld_d;
  result_t                res_q, res_d;

  logic               take, done, ok;
  logic [CpWidth-1:0] cp, v;

  assign take         = beat_valid_i && (!out_vld_q || pop_i);
  assign beat_ready_o = take;
  assign result_o     = res_q;
  assign empty_o      = !out_vld_q;

  assign v = {partial_q[CpWidth-7:0], beat_i.data[5:0]};

  always_comb begin
    case (len_q)
      2'd1:    ok = (v >= MinTwoByte);
      2'd2:    ok = (v >= MinThreeByte) && !((v >= SurrogateLo) && (v <= SurrogateHi));
      default: ok = (v >= MinFourByte) && (v <= MaxScalar);
    endcase
  end

  always_comb begin
    partial_d = partial_q;
    rem_d     = rem_q;
    len_d     = len_q;
    err_d     = err_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    out_vld_d = out_vld_q && !pop_i;
    done      = 1'b0;
    cp        = '0;
    if (take) begin
      if (!err_q) begin
        if (rem_q == 2'd0) begin
          case (beat_i.cls)
            CLS_ASCII: begin
              cp   = CpWidth'(beat_i.data);
              done = 1'b1;
            end
            CLS_LEAD2: begin
              partial_d = CpWidth'(beat_i.data[4:0]);
              rem_d     = 2'd1;
              len_d     = 2'd1;
            end
            CLS_LEAD3: begin
              partial_d = CpWidth'(beat_i.data[3:0]);
              rem_d     = 2'd2;
              len_d     = 2'd2;
            end
            CLS_LEAD4: begin
              partial_d = CpWidth'(beat_i.data[2:0]);
              rem_d     = 2'd3;
              len_d     = 2'd3;
            end
            default: begin
              err_d     = 1'b1;
              partial_d = '0;
              rem_d     = 2'd0;
              len_d     = 2'd0;
            end
          endcase
        end else if (beat_i.cls != CLS_CONT) begin
          err_d     = 1'b1;
          partial_d = '0;
          rem_d     = 2'd0;
          len_d     = 2'd0;
        end else begin
          partial_d = v;
          rem_d     = rem_q - 2'd1;
          if (rem_q == 2'd1) begin
            if (ok) begin
              cp   = v;
              done = 1'b1;
            end else begin
              err_d = 1'b1;
            end
            partial_d = '0;
            len_d     = 2'd0;
          end
        end
      end
      if (done && (cnt_q != '1)) begin
        cnt_d = cnt_q + 1'b1;
      end
      if (beat_i.last && !err_d && (rem_d != 2'd0)) begin
        err_d     = 1'b1;
        partial_d = '0;
        rem_d     = 2'd0;
        len_d     = 2'd0;
      end
      if (done || beat_i.last) begin
        out_vld_d            = 1'b1;
        res_d.code_point     = err_d ? '0 : cp;
        res_d.has_code_point = done && !err_d;
        res_d.status         = err_d;
        res_d.end_of_message = beat_i.last;
        res_d.decoded_count  = OutCntW'(cnt_d);
      end
      if (beat_i.last) begin
        partial_d = '0;
        rem_d     = 2'd0;
        len_d     = 2'd0;
        err_d     = 1'b0;
        cnt_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      rem_q     <= 2'd0;
      len_q     <= 2'd0;
      err_q     <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      partial_q <= partial_d;
      rem_q     <= rem_d;
      len_q     <= len_d;
      err_q     <= err_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  a_cp_only_when_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.has_code_point |-> !res_q.status)
    else $error("code point flagged on a failed message");

  a_err_zero_cp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.status |-> (res_q.code_point == '0))
    else $error("non-zero code point on error result");

  a_rem_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= len_q)
    else $error("remaining continuation count exceeds sequence length");

  a_err_no_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> (rem_q == 2'd0) && (partial_q == '0))
    else $error("sequence state left over after error");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !pop_i |=> out_vld_q && $stable(res_q))
    else $error("stalled result changed");

endmodule

[src/utf8_stream_decoder.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Validating decoder of byte messages into Unicode scalar values.
// ----------------------------------------------------------------------------
// Input channel: one message byte per beat on in_byte_i, last_byte_i marks the
// final byte. A beat is taken on a rising edge with push high and full low.
// Result channel: while empty is low the oldest result sits on the result
// ports; it is taken on a rising edge with pop high. A result is given for
// each completed code point and always one for the last byte of a message,
// with end_of_message_o set and status_o reporting invalid UTF-8. After an
// error, bytes up to the last byte give no result.
// A result reaches the result ports through the front register, the beat
// queue and the result register, in that order. Throughput is one byte per
// cycle while pop keeps the result register draining.
// When pop is held low the result register holds, the back end stops and the
// two-entry beat queue and front register fill; full rises once all three
// are occupied. Reset clears all message state and empties every stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_stream_decoder import utf8d_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_byte_i,
  input  logic               last_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic [CpWidth-1:0] code_point_o,
  output logic               has_code_point_o,
  output logic               status_o,
  output logic               end_of_message_o,
  output logic [OutCntW-1:0] decoded_count_o
);

  logic    in_ready;
  beat_t   fr_beat, q_beat;
  logic    fr_valid, fr_ready, q_valid, q_ready;
  result_t res;

  assign full = !in_ready;

  utf8d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (push),
    .in_ready_o   (in_ready),
    .in_byte_i    (in_byte_i),
    .last_byte_i  (last_byte_i),
    .beat_o       (fr_beat),
    .beat_valid_o (fr_valid),
    .beat_ready_i (fr_ready)
  );

  utf8d_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .data_i       (fr_beat),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .data_o       (q_beat)
  );

  utf8d_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (q_beat),
    .beat_valid_i (q_valid),
    .beat_ready_o (q_ready),
    .result_o     (res),
    .empty_o      (empty),
    .pop_i        (pop)
  );

  assign code_point_o     = res.code_point;
  assign has_code_point_o = res.has_code_point;
  assign status_o         = res.status;
  assign end_of_message_o = res.end_of_message;
  assign decoded_count_o  = res.decoded_count;

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Drives byte messages through the decoder with random gaps on both queue
// sides and compares every popped result with an in-bench decode of the same
// bytes: directed edge cases, random well-formed and faulty messages and a
// long consumer hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import utf8d_pkg::*;

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned RandomBytes = 600;

  typedef enum int {
    FLT_OVERLONG,
    FLT_SURROGATE,
    FLT_TOO_BIG,
    FLT_BAD_LEAD,
    FLT_BAD_CONT,
    FLT_TRUNCATED,
    FLT_NOISE
  } fault_e;

  class utf8_point_log;
    result_t            pending_points[$];
    int unsigned        fails;
    logic [CpWidth-1:0] partial;
    logic [1:0]         remaining;
    logic [1:0]         seq_len;
    bit                 err_seen;
    logic [OutCntW-1:0] count;

    function new();
      fails = 0;
      clear();
    endfunction

    function void clear();
      partial   = '0;
      remaining = '0;
      seq_len   = '0;
      err_seen  = 1'b0;
      count     = '0;
    endfunction

    function void flag_error();
      err_seen  = 1'b1;
      remaining = '0;
      seq_len   = '0;
      partial   = '0;
    endfunction

    function bit scalar_ok(logic [CpWidth-1:0] v, logic [1:0] cont);
      case (cont)
        2'd1: return v >= MinTwoByte;
        2'd2: return v >= MinThreeByte && !(v >= SurrogateLo && v <= SurrogateHi);
        default: return v >= MinFourByte && v <= MaxScalar;
      endcase
    endfunction

    // decode one accepted byte and queue the result it gives, if any
    function void take_byte(logic [7:0] b, logic last);
      bit                 done;
      logic [CpWidth-1:0] cp;
      result_t            r;
      done = 1'b0;
      cp   = '0;
      if (!err_seen) begin
        if (remaining == 2'd0) begin
          if (!b[7]) begin
            cp   = {13'd0, b};
            done = 1'b1;
          end else if (b[7:5] == 3'b110) begin
            partial   = {16'd0, b[4:0]};
            remaining = 2'd1;
            seq_len   = 2'd1;
          end else if (b[7:4] == 4'b1110) begin
            partial   = {17'd0, b[3:0]};
            remaining = 2'd2;
            seq_len   = 2'd2;
          end else if (b[7:3] == 5'b11110) begin
            partial   = {18'd0, b[2:0]};
            remaining = 2'd3;
            seq_len   = 2'd3;
          end else begin
            flag_error();
          end
        end else if (b[7:6] != 2'b10) begin
          flag_error();
        end else begin
          partial   = {partial[CpWidth-7:0], b[5:0]};
          remaining = remaining - 2'd1;
          if (remaining == 2'd0) begin
            if (scalar_ok(partial, seq_len)) begin
              cp   = partial;
              done = 1'b1;
            end else begin
              flag_error();
            end
            partial = '0;
            seq_len = '0;
          end
        end
      end
      if (done && count != '1) count = count + 1'b1;
      if (last && !err_seen && remaining != 2'd0) flag_error();
      if (done || last) begin
        r.code_point     = err_seen ? '0 : cp;
        r.has_code_point = done && !err_seen;
        r.status         = err_seen;
        r.end_of_message = last;
        r.decoded_count  = count;
        pending_points.push_back(r);
      end
      if (last) clear();
    endfunction

    function void check_point(result_t got);
      result_t want;
      if (pending_points.size() == 0) begin
        $error("unexpected result: code_point %h status %b", got.code_point, got.status);
        fails++;
        return;
      end
      want = pending_points.pop_front();
      if (got.code_point !== want.code_point) begin
        $error("code_point: expected %h, got %h", want.code_point, got.code_point);
        fails++;
      end
      if (got.has_code_point !== want.has_code_point) begin
        $error("has_code_point: expected %b, got %b", want.has_code_point,
               got.has_code_point);
        fails++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %b, got %b", want.status, got.status);
        fails++;
      end
      if (got.end_of_message !== want.end_of_message) begin
        $error("end_of_message: expected %b, got %b", want.end_of_message,
               got.end_of_message);
        fails++;
      end
      if (got.decoded_count !== want.decoded_count) begin
        $error("decoded_count: expected %0d, got %0d", want.decoded_count,
               got.decoded_count);
        fails++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [7:0]         in_byte_i = 8'h00;
  logic               last_byte_i = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [CpWidth-1:0] code_point_o;
  logic               has_code_point_o;
  logic               status_o;
  logic               end_of_message_o;
  logic [OutCntW-1:0] decoded_count_o;

  utf8_point_log book = new();
  int unsigned   items_sent = 0;
  int unsigned   cycle_count = 0;
  int unsigned   rx_hold_cycles = 0;
  bit            tx_no_idle = 1'b0;
  bit            rx_no_idle = 1'b0;

  utf8_stream_decoder u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .in_byte_i        (in_byte_i),
    .last_byte_i      (last_byte_i),
    .empty            (empty),
    .pop              (pop),
    .code_point_o     (code_point_o),
    .has_code_point_o (has_code_point_o),
    .status_o         (status_o),
    .end_of_message_o (end_of_message_o),
    .decoded_count_o  (decoded_count_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    @(negedge clk_i);
    push        = 1'b1;
    in_byte_i   = b;
    last_byte_i = last;
    do @(posedge clk_i); while (full);
    book.take_byte(b, last);
    items_sent++;
    gap = tx_no_idle ? 0 : idle_len();
    if (gap != 0) begin
      @(negedge clk_i);
      push = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_message(input logic [7:0] msg[$]);
    foreach (msg[k]) send_byte(msg[k], k == msg.size() - 1);
  endtask

  function automatic void put_seq(ref logic [7:0] q[$], input logic [CpWidth-1:0] v,
                                  input int len);
    case (len)
      1: q.push_back(v[7:0]);
      2: begin
        q.push_back({3'b110, v[10:6]});
        q.push_back({2'b10, v[5:0]});
      end
      3: begin
        q.push_back({4'b1110, v[15:12]});
        q.push_back({2'b10, v[11:6]});
        q.push_back({2'b10, v[5:0]});
      end
      default: begin
        q.push_back({5'b11110, v[20:18]});
        q.push_back({2'b10, v[17:12]});
        q.push_back({2'b10, v[11:6]});
        q.push_back({2'b10, v[5:0]});
      end
    endcase
  endfunction

  task automatic pick_scalar(output logic [CpWidth-1:0] v, output int len);
    logic [CpWidth-1:0] lo;
    logic [CpWidth-1:0] hi;
    len = $urandom_range(1, 4);
    case (len)
      1: begin
        lo = 21'h0;
        hi = 21'h7F;
      end
      2: begin
        lo = MinTwoByte;
        hi = MinThreeByte - 1;
      end
      3: begin
        lo = MinThreeByte;
        hi = MinFourByte - 1;
      end
      default: begin
        lo = MinFourByte;
        hi = MaxScalar;
      end
    endcase
    v = CpWidth'($urandom_range(hi, lo));
    if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 1) ? lo : hi;
    if (len == 3 && v >= SurrogateLo && v <= SurrogateHi) v = v ^ 21'h4000;
  endtask

  task automatic build_message(ref logic [7:0] msg[$]);
    logic [7:0]         seq[$];
    logic [CpWidth-1:0] v;
    logic [7:0]         bad;
    int                 len;
    int                 n_points;
    int                 fault_at;
    fault_e             kind;
    msg.delete();
    n_points = $urandom_range(1, 6);
    fault_at = -1;
    if ($urandom_range(0, 99) < 30) fault_at = $urandom_range(0, n_points - 1);
    kind = fault_e'($urandom_range(0, FLT_NOISE));
    for (int i = 0; i < n_points; i++) begin
      seq.delete();
      pick_scalar(v, len);
      if (i != fault_at) begin
        put_seq(seq, v, len);
      end else begin
        case (kind)
          FLT_OVERLONG: begin
            len = $urandom_range(2, 4);
            v = CpWidth'($urandom_range(len == 2 ? 21'h7F :
                                        len == 3 ? 21'h7FF : 21'hFFFF, 0));
            put_seq(seq, v, len);
          end
          FLT_SURROGATE: begin
            v = CpWidth'($urandom_range(SurrogateHi, SurrogateLo));
            put_seq(seq, v, 3);
          end
          FLT_TOO_BIG: begin
            v = CpWidth'($urandom_range(21'h1FFFFF, MaxScalar + 1));
            put_seq(seq, v, 4);
          end
          FLT_BAD_LEAD: begin
            seq.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'hBF, 8'h80))
                                               : 8'($urandom_range(8'hFF, 8'hF8)));
          end
          FLT_BAD_CONT, FLT_TRUNCATED: begin
            while (len == 1) pick_scalar(v, len);
            put_seq(seq, v, len);
            if (kind == FLT_BAD_CONT) begin
              bad = 8'($urandom_range(0, 255));
              while (bad[7:6] == 2'b10) bad = 8'($urandom_range(0, 255));
              seq[$urandom_range(1, len - 1)] = bad;
            end else begin
              seq = seq[0:$urandom_range(0, len - 2)];
            end
          end
          default: begin
            repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom_range(0, 255)));
          end
        endcase
      end
      foreach (seq[k]) msg.push_back(seq[k]);
      if (i == fault_at && kind == FLT_TRUNCATED) break;
    end
  endtask

  initial begin : result_side
    int unsigned gap;
    result_t     got;
    @(posedge rst_ni);
    forever begin
      gap = rx_no_idle ? 0 : idle_len();
      if (rx_hold_cycles != 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (gap != 0) begin
        @(negedge clk_i);
        pop = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      pop = 1'b1;
      do @(posedge clk_i); while (empty);
      got.code_point     = code_point_o;
      got.has_code_point = has_code_point_o;
      got.status         = status_o;
      got.end_of_message = end_of_message_o;
      got.decoded_count  = decoded_count_o;
      book.check_point(got);
    end
  end

  initial begin : stimulus
    logic [7:0]  msg[$];
    int unsigned msg_idx;
    int unsigned stop_at;
    bit          held;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // ASCII extremes and smallest two-byte, then smallest three-byte and largest scalar
    msg = '{8'h00, 8'hC2, 8'h80, 8'h7F};
    send_message(msg);
    msg = '{8'hE0, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_message(msg);
    // overlong, ending on the completing byte
    msg = '{8'hC0, 8'h80};
    send_message(msg);
    // surrogate
    msg = '{8'hED, 8'hA0, 8'h80};
    send_message(msg);
    // above the scalar range
    msg = '{8'hF4, 8'h90, 8'h80, 8'h80};
    send_message(msg);
    // bad lead, stray continuation
    msg = '{8'hFF};
    send_message(msg);
    msg = '{8'h80};
    send_message(msg);
    // bad continuation, then truncation at the last byte
    msg = '{8'hE2, 8'h41};
    send_message(msg);
    msg = '{8'hF0, 8'h9F};
    send_message(msg);

    msg_idx = 0;
    held    = 1'b0;
    stop_at = items_sent + RandomBytes;
    while (items_sent < stop_at) begin
      tx_no_idle = ((msg_idx / 16) % 4) == 3;
      rx_no_idle = ((msg_idx / 16) % 4) >= 2;
      if (!held && items_sent >= stop_at - RandomBytes / 2) begin
        held           = 1'b1;
        tx_no_idle     = 1'b1;
        rx_hold_cycles = 300;
      end
      build_message(msg);
      send_message(msg);
      msg_idx++;
    end

    @(negedge clk_i);
    push = 1'b0;

    while (book.pending_points.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (book.fails == 0 && book.pending_points.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
